### rtl/core/rgbh_pkg.sv
`timescale 1ns / 1ps

package rgbh_pkg;

  localparam int BIN_COUNT        = 256;
  localparam int BIN_W            = $clog2(BIN_COUNT);
  localparam int DEF_COUNT_BITS   = 24;
  localparam int OUT_BITS         = 24;
  localparam int MAX_DIMENSION    = 4096;
  localparam int COORD_W          = 12;
  localparam int VALUE_W          = 8;
  localparam int OP_W             = 2;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_PIXEL = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row_index;
    logic [VALUE_W-1:0] blue_value;
    logic [VALUE_W-1:0] green_value;
    logic [VALUE_W-1:0] red_value;
    logic [BIN_W-1:0]   bin_select;
  } req_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] red_count;
    logic [OUT_BITS-1:0] green_count;
    logic [OUT_BITS-1:0] blue_count;
    logic [OUT_BITS-1:0] peak_count;
  } rsp_t;

  // Control from the sequencer to each color lane.
  typedef struct packed {
    logic lookup;
    logic clear;
    logic update;
    logic count_en;
  } lane_ctl_t;

  // Control from the sequencer to the peak merge stage.
  typedef struct packed {
    logic clear;
    logic merge;
    logic count_en;
  } merge_ctl_t;

endpackage

### rtl/core/rgbh_req_if.sv
`timescale 1ns / 1ps

interface rgbh_req_if;
  logic          valid;
  logic          ready;
  rgbh_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/rgbh_rsp_if.sv
`timescale 1ns / 1ps

interface rgbh_rsp_if;
  logic          valid;
  logic          ready;
  rgbh_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/rgb_histogram_subsampled_core.sv
`timescale 1ns / 1ps
// An accepted request goes through the lookup, write-back and peak merge steps
// that each color lane's single RAM goes through per pixel; the merge waits
// while a result is unread, and no request is taken until it is done. Clear
// and read requests take the same steps. Reset (synchronous, rst) zeroes all
// bins through per-bin valid bits at once and sets the peak to one.

module rgb_histogram_subsampled_core #(
  parameter int COUNT_BITS = rgbh_pkg::DEF_COUNT_BITS
) (
  input logic        clk,
  input logic        rst,
  rgbh_req_if.sink   request,
  rgbh_rsp_if.source result
);
  import rgbh_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_UPDATE = 2'd1;
  localparam logic [1:0] S_MERGE  = 2'd2;

  logic [1:0]            state;
  logic [OP_W-1:0]       op_q;
  logic                  count_en_q;
  logic                  res_valid;
  rsp_t                  res_data;

  logic                  accept;
  logic                  out_free;
  logic                  pixel_hit;
  lane_ctl_t             lane_ctl;
  merge_ctl_t            merge_ctl;
  logic [BIN_W-1:0]      red_addr;
  logic [BIN_W-1:0]      green_addr;
  logic [BIN_W-1:0]      blue_addr;
  logic [COUNT_BITS-1:0] red_cnt;
  logic [COUNT_BITS-1:0] green_cnt;
  logic [COUNT_BITS-1:0] blue_cnt;
  logic [COUNT_BITS-1:0] peak_new;

  function automatic logic [OUT_BITS-1:0] to_out(input logic [COUNT_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[OUT_BITS-1:0];
  endfunction

  assign request.ready = (state == S_IDLE);
  assign accept        = request.valid && request.ready;
  assign out_free      = !res_valid || result.ready;

  // Only pixels on even rows and columns inside the frame are counted.
  assign pixel_hit = (request.data.operation == OP_PIXEL)
                  && !request.data.column[0] && !request.data.row_index[0]
                  && (32'(request.data.column) < 32'(MAX_DIMENSION))
                  && (32'(request.data.row_index) < 32'(MAX_DIMENSION));

  assign red_addr   = (request.data.operation == OP_READ) ? request.data.bin_select
                                                          : request.data.red_value;
  assign green_addr = (request.data.operation == OP_READ) ? request.data.bin_select
                                                          : request.data.green_value;
  assign blue_addr  = (request.data.operation == OP_READ) ? request.data.bin_select
                                                          : request.data.blue_value;

  always_comb begin
    lane_ctl.lookup    = accept;
    lane_ctl.clear     = accept && (request.data.operation == OP_CLEAR);
    lane_ctl.update    = (state == S_UPDATE);
    lane_ctl.count_en  = count_en_q;
    merge_ctl.clear    = lane_ctl.clear;
    merge_ctl.merge    = (state == S_MERGE) && out_free;
    merge_ctl.count_en = count_en_q;
  end

  rgbh_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_red (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lane_ctl),
    .addr  (red_addr),
    .count (red_cnt)
  );

  rgbh_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_green (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lane_ctl),
    .addr  (green_addr),
    .count (green_cnt)
  );

  rgbh_lane #(.COUNT_BITS(COUNT_BITS)) u_lane_blue (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lane_ctl),
    .addr  (blue_addr),
    .count (blue_cnt)
  );

  rgbh_merge #(.COUNT_BITS(COUNT_BITS)) u_merge (
    .clk         (clk),
    .rst         (rst),
    .ctl         (merge_ctl),
    .red_count   (red_cnt),
    .green_count (green_cnt),
    .blue_count  (blue_cnt),
    .peak_new    (peak_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count_en_q <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            count_en_q <= pixel_hit;
            state      <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state <= S_MERGE;
        end
        S_MERGE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (merge_ctl.merge) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= request.data.operation;
    end
    if (merge_ctl.merge) begin
      res_data.red_count   <= (op_q == OP_READ) ? to_out(red_cnt) : '0;
      res_data.green_count <= (op_q == OP_READ) ? to_out(green_cnt) : '0;
      res_data.blue_count  <= (op_q == OP_READ) ? to_out(blue_cnt) : '0;
      res_data.peak_count  <= to_out(peak_new);
    end
  end

  assign result.valid = res_valid;
  assign result.data  = res_data;

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_UPDATE)
    else $error("accepted request did not start a lane update");

  a_update_to_merge: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE |=> state == S_MERGE)
    else $error("lane update not followed by merge");

  a_merge_emits: assert property (@(posedge clk) disable iff (rst)
    merge_ctl.merge |=> res_valid && state == S_IDLE)
    else $error("merge did not present a result");

  a_peak_covers: assert property (@(posedge clk) disable iff (rst)
    state == S_MERGE && count_en_q |->
      peak_new >= red_cnt && peak_new >= green_cnt && peak_new >= blue_cnt)
    else $error("peak below an updated bin count");

endmodule

### rtl/core/rgbh_ram.sv
`timescale 1ns / 1ps

module rgbh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/rgbh_lane.sv
`timescale 1ns / 1ps

module rgbh_lane #(
  parameter int COUNT_BITS = rgbh_pkg::DEF_COUNT_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rgbh_pkg::lane_ctl_t       ctl,
  input  logic [rgbh_pkg::BIN_W-1:0] addr,
  output logic [COUNT_BITS-1:0]     count
);
  import rgbh_pkg::*;

  logic [BIN_COUNT-1:0]  valid;
  logic [BIN_W-1:0]      addr_q;
  logic                  hit;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] inc;
  logic                  wr_en;

  rgbh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BIN_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr_q),
    .wr_data (inc),
    .rd_en   (ctl.lookup),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // A bin that has not been written since the last clear reads as zero.
  assign cur   = hit ? rd_data : '0;
  assign inc   = (cur == {COUNT_BITS{1'b1}}) ? cur : cur + COUNT_BITS'(1);
  assign wr_en = ctl.update && ctl.count_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.lookup) begin
      addr_q <= addr;
      hit    <= valid[addr];
    end
    if (ctl.update) begin
      count <= ctl.count_en ? inc : cur;
    end
  end

endmodule

### rtl/core/rgbh_merge.sv
`timescale 1ns / 1ps

module rgbh_merge #(
  parameter int COUNT_BITS = rgbh_pkg::DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rgbh_pkg::merge_ctl_t  ctl,
  input  logic [COUNT_BITS-1:0] red_count,
  input  logic [COUNT_BITS-1:0] green_count,
  input  logic [COUNT_BITS-1:0] blue_count,
  output logic [COUNT_BITS-1:0] peak_new
);
  import rgbh_pkg::*;

  logic [COUNT_BITS-1:0] peak;
  logic [COUNT_BITS-1:0] max_rg;
  logic [COUNT_BITS-1:0] max_bp;
  logic [COUNT_BITS-1:0] max_all;

  assign max_rg   = (red_count > green_count) ? red_count : green_count;
  assign max_bp   = (blue_count > peak) ? blue_count : peak;
  assign max_all  = (max_rg > max_bp) ? max_rg : max_bp;
  assign peak_new = ctl.count_en ? max_all : peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak <= COUNT_BITS'(1);
    end else if (ctl.clear) begin
      peak <= COUNT_BITS'(1);
    end else if (ctl.merge) begin
      peak <= peak_new;
    end
  end

endmodule
